[src/acp_pkg.sv]
// Shared constants and types for the azimuth command parser.
package acp_pkg;

  localparam int unsigned DIGIT_COUNT_DEFAULT = 3;

  localparam int unsigned ANGLE_W  = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RELAY_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Characters of the command stream.
  localparam logic [7:0] CHAR_UPPER_M = 8'h4D;
  localparam logic [7:0] CHAR_LOWER_M = 8'h6D;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] DECIMAL_BASE = 8'd10;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CMD   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  // Relay codes.
  localparam logic [RELAY_W-1:0] RELAY_NORTH = 2'd0;
  localparam logic [RELAY_W-1:0] RELAY_EAST  = 2'd1;
  localparam logic [RELAY_W-1:0] RELAY_SOUTH = 2'd2;
  localparam logic [RELAY_W-1:0] RELAY_WEST  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CIRCLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EAST        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEST        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX         = 3'd5;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ANGLE_W-1:0]  value;
    logic [RELAY_W-1:0]  relay;
    logic                led;
  } acp_result_t;

endpackage

[src/azimuth_command_parser.sv]
// Azimuth command parser: decodes M<ddd><CR> commands into a quadrant relay select.
//
// Takes one received byte per clock cycle while in_ready is high and returns
// one registered result beat per byte. Every byte is decoded by a single
// compare, multiply-by-ten and threshold stage between the input handshake and
// the result register, so with out_ready high the sustained rate is one byte per
// cycle. A one-entry skid stage behind the result register lets the block take
// one more byte while a result waits; in_ready drops only while that skid entry
// is occupied. The fault LED, once driven low by an out-of-range command, stays
// low until reset. Configuration is written through cfg_we/cfg_index/cfg_data
// with no wait; indexes beyond the last register are ignored.
module azimuth_command_parser
  import acp_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [ANGLE_W-1:0]   azimuth_value,
  output logic [RELAY_W-1:0]   relay_select,
  output logic                 fault_led,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ANGLE_W-1:0]   cfg_data
);

  localparam logic [1:0] LAST_DIGIT = 2'(DIGIT_COUNT);

  logic [ANGLE_W-1:0] full_circle_angle;
  logic [ANGLE_W-1:0] north_threshold;
  logic [ANGLE_W-1:0] east_threshold;
  logic [ANGLE_W-1:0] south_threshold;
  logic [ANGLE_W-1:0] west_threshold;
  logic [ANGLE_W-1:0] max_azimuth;

  logic               collecting, collecting_next;
  logic [1:0]         digit_count, digit_count_next;
  logic [ANGLE_W-1:0] accumulated_value, accumulated_value_next;
  logic [RELAY_W-1:0] current_relay, current_relay_next;
  logic               led_level, led_level_next;

  logic               res_valid;
  acp_result_t        res;
  logic               skid_valid;
  acp_result_t        skid;
  acp_result_t        step_res;

  logic               accept;
  logic               pop;
  logic [7:0]         digit;
  logic [13:0]        times_ten;
  logic [ANGLE_W-1:0] angle;
  logic [RELAY_W-1:0] quadrant;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = res_valid && out_ready;

  assign out_valid     = res_valid;
  assign status        = res.status;
  assign azimuth_value = res.value;
  assign relay_select  = res.relay;
  assign fault_led     = res.led;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_circle_angle <= 10'd360;
      north_threshold   <= 10'd45;
      east_threshold    <= 10'd135;
      south_threshold   <= 10'd225;
      west_threshold    <= 10'd315;
      max_azimuth       <= 10'd450;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FULL_CIRCLE: full_circle_angle <= cfg_data;
        REG_NORTH:       north_threshold   <= cfg_data;
        REG_EAST:        east_threshold    <= cfg_data;
        REG_SOUTH:       south_threshold   <= cfg_data;
        REG_WEST:        west_threshold    <= cfg_data;
        REG_MAX:         max_azimuth       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Quadrant pick for the value collected so far.
  always_comb begin
    angle = (accumulated_value > full_circle_angle) ?
            accumulated_value - full_circle_angle : accumulated_value;
    if (angle > west_threshold) begin
      quadrant = RELAY_NORTH;
    end else if (angle > south_threshold) begin
      quadrant = RELAY_WEST;
    end else if (angle > east_threshold) begin
      quadrant = RELAY_SOUTH;
    end else if (angle > north_threshold) begin
      quadrant = RELAY_EAST;
    end else begin
      quadrant = RELAY_NORTH;
    end
  end

  assign digit     = rx_byte - CHAR_ZERO;
  assign times_ten = 14'(accumulated_value) * 14'd10;

  always_comb begin
    collecting_next        = collecting;
    digit_count_next       = digit_count;
    accumulated_value_next = accumulated_value;
    current_relay_next     = current_relay;
    led_level_next         = led_level;
    step_res.status        = ST_BUSY;
    step_res.value         = '0;

    if (!collecting) begin
      if (rx_byte == CHAR_UPPER_M || rx_byte == CHAR_LOWER_M) begin
        collecting_next        = 1'b1;
        digit_count_next       = '0;
        accumulated_value_next = '0;
      end else begin
        step_res.status = ST_BAD_CMD;
      end
    end else if (digit_count >= LAST_DIGIT) begin
      collecting_next = 1'b0;
      if (rx_byte == CHAR_CR) begin
        step_res.value = accumulated_value;
        if (accumulated_value <= max_azimuth) begin
          current_relay_next = quadrant;
          step_res.status    = ST_OK;
        end else begin
          led_level_next  = 1'b0;
          step_res.status = ST_RANGE;
        end
      end else begin
        step_res.status = ST_BAD_DIGIT;
      end
    end else if (digit < DECIMAL_BASE) begin
      accumulated_value_next = times_ten[ANGLE_W-1:0] + ANGLE_W'(digit);
      digit_count_next       = digit_count + 2'd1;
    end else begin
      collecting_next = 1'b0;
      step_res.status = ST_BAD_DIGIT;
    end

    step_res.relay = current_relay_next;
    step_res.led   = led_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting        <= 1'b0;
      digit_count       <= '0;
      accumulated_value <= '0;
      current_relay     <= RELAY_NORTH;
      led_level         <= 1'b1;
    end else if (accept) begin
      collecting        <= collecting_next;
      digit_count       <= digit_count_next;
      accumulated_value <= accumulated_value_next;
      current_relay     <= current_relay_next;
      led_level         <= led_level_next;
    end
  end

  // Result register with a one-beat skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || pop) begin
      if (skid_valid) begin
        res        <= skid;
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept;
        if (accept) begin
          res <= step_res;
        end
      end
    end else if (accept) begin
      skid       <= step_res;
      skid_valid <= 1'b1;
    end
  end

endmodule

[verif/azimuth_command_parser_test.sv]
// Testbench for the azimuth command parser: result prediction, stimulus and checks.
`timescale 1ns / 1ps

module azimuth_command_parser_test
  import acp_pkg::*;
;

  // Indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned BYTES_PER_PHASE = 230;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned PRINT_CAP       = 30;

  class azimuth_scoreboard;
    logic [ANGLE_W-1:0] full_circle, north_lim, east_lim, south_lim, west_lim, max_angle;
    bit                 in_command;
    int unsigned        digits_seen;
    logic [ANGLE_W-1:0] partial_angle;
    logic [RELAY_W-1:0] relay_now;
    logic               led_now;
    acp_result_t        expected_q[$];
    int unsigned        mismatches;
    int unsigned        beats_checked;
    int unsigned        ok_seen, bad_cmd_seen, bad_digit_seen, range_seen;

    function new();
      full_circle   = 10'd360;
      north_lim     = 10'd45;
      east_lim      = 10'd135;
      south_lim     = 10'd225;
      west_lim      = 10'd315;
      max_angle     = 10'd450;
      in_command    = 1'b0;
      digits_seen   = 0;
      partial_angle = '0;
      relay_now     = RELAY_NORTH;
      led_now       = 1'b1;
      mismatches    = 0;
      beats_checked = 0;
      ok_seen       = 0;
      bad_cmd_seen  = 0;
      bad_digit_seen = 0;
      range_seen    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ANGLE_W-1:0] data);
      case (idx)
        REG_FULL_CIRCLE: full_circle = data;
        REG_NORTH:       north_lim   = data;
        REG_EAST:        east_lim    = data;
        REG_SOUTH:       south_lim   = data;
        REG_WEST:        west_lim    = data;
        REG_MAX:         max_angle   = data;
        default: ;
      endcase
    endfunction

    function logic [RELAY_W-1:0] quadrant_for(logic [ANGLE_W-1:0] angle);
      logic [ANGLE_W-1:0] a;
      a = angle;
      if (a > full_circle) a = a - full_circle;
      if (a > west_lim) return RELAY_NORTH;
      if (a > south_lim) return RELAY_WEST;
      if (a > east_lim) return RELAY_SOUTH;
      if (a > north_lim) return RELAY_EAST;
      return RELAY_NORTH;
    endfunction

    // Works out the one result beat that an accepted byte causes.
    function void note_byte(logic [7:0] b);
      acp_result_t r;
      logic [7:0]  d;
      r.status = ST_BUSY;
      r.value  = '0;
      if (!in_command) begin
        if (b == CHAR_UPPER_M || b == CHAR_LOWER_M) begin
          in_command    = 1'b1;
          digits_seen   = 0;
          partial_angle = '0;
        end else begin
          r.status = ST_BAD_CMD;
        end
      end else if (digits_seen >= DIGIT_COUNT_DEFAULT) begin
        // Anything but CR here is a digit error, even a start character.
        in_command = 1'b0;
        if (b == CHAR_CR) begin
          r.value = partial_angle;
          if (partial_angle <= max_angle) begin
            relay_now = quadrant_for(partial_angle);
            r.status  = ST_OK;
          end else begin
            led_now  = 1'b0;
            r.status = ST_RANGE;
          end
        end else begin
          r.status = ST_BAD_DIGIT;
        end
      end else begin
        d = b - CHAR_ZERO;
        if (d < DECIMAL_BASE) begin
          partial_angle = partial_angle * 10'(DECIMAL_BASE) + 10'(d);
          digits_seen++;
        end else begin
          in_command = 1'b0;
          r.status   = ST_BAD_DIGIT;
        end
      end
      r.relay = relay_now;
      r.led   = led_now;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [ANGLE_W-1:0] got, logic [ANGLE_W-1:0] wanted);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("[%0t] mismatch at result beat %0d: %s got %0h, expected %0h",
                 $realtime, beats_checked, what, got, wanted);
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [ANGLE_W-1:0] val,
                      logic [RELAY_W-1:0] rel, logic led);
      acp_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("beat with nothing pending, status", 10'(st), '0);
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status) report_mismatch("status", 10'(st), 10'(want.status));
      if (val !== want.value) report_mismatch("azimuth_value", val, want.value);
      if (rel !== want.relay) report_mismatch("relay_select", 10'(rel), 10'(want.relay));
      if (led !== want.led) report_mismatch("fault_led", 10'(led), 10'(want.led));
      case (want.status)
        ST_OK:        ok_seen++;
        ST_BAD_CMD:   bad_cmd_seen++;
        ST_BAD_DIGIT: bad_digit_seen++;
        ST_RANGE:     range_seen++;
        default: ;
      endcase
      beats_checked++;
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [ANGLE_W-1:0]   azimuth_value;
  logic [RELAY_W-1:0]   relay_select;
  logic                 fault_led;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ANGLE_W-1:0]   cfg_data = '0;

  azimuth_scoreboard sb;
  int unsigned       bytes_sent = 0;
  int unsigned       settings_loaded = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;

  azimuth_command_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .azimuth_value (azimuth_value),
    .relay_select  (relay_select),
    .fault_led     (fault_led),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // The input beat is noted before the output beat is checked, so a same-edge
  // pair never depends on process order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(rx_byte);
      if (out_valid && out_ready)
        sb.check_result(status, azimuth_value, relay_select, fault_led);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
      gap = $urandom_range(1, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_command(input logic [7:0] lead, input logic [ANGLE_W-1:0] angle,
                              input logic [7:0] tail);
    send_byte(lead);
    send_byte(CHAR_ZERO + 8'(angle / 100));
    send_byte(CHAR_ZERO + 8'((angle / 10) % 10));
    send_byte(CHAR_ZERO + 8'(angle % 10));
    send_byte(tail);
  endtask

  function automatic logic [7:0] start_char();
    return ($urandom_range(0, 1) != 0) ? CHAR_UPPER_M : CHAR_LOWER_M;
  endfunction

  // Half the angles sit within two of some register value to hit the compares.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [CFG_IDX_W-1:0] which;
    logic [ANGLE_W-1:0]   base;
    int                   v;
    if ($urandom_range(0, 1) == 0) return 10'($urandom_range(0, 999));
    which = 3'($urandom_range(REG_FULL_CIRCLE, REG_MAX));
    case (which)
      REG_FULL_CIRCLE: base = sb.full_circle;
      REG_NORTH:       base = sb.north_lim;
      REG_EAST:        base = sb.east_lim;
      REG_SOUTH:       base = sb.south_lim;
      REG_WEST:        base = sb.west_lim;
      default:         base = sb.max_angle;
    endcase
    v = int'(base) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 999) v = 999;
    return 10'(v);
  endfunction

  task automatic send_random_sequence();
    int unsigned kind, k, i;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      send_command(start_char(), pick_angle(), CHAR_CR);
    end else if (kind < 80) begin
      // Command cut short by a non-digit.
      send_byte(start_char());
      k = $urandom_range(0, 2);
      for (i = 0; i < k; i++) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
      do b = 8'($urandom); while (b >= CHAR_ZERO && b < CHAR_ZERO + DECIMAL_BASE);
      send_byte(b);
    end else if (kind < 88) begin
      // Three good digits, then the wrong terminator.
      if ($urandom_range(0, 1) != 0) b = start_char();
      else do b = 8'($urandom); while (b == CHAR_CR);
      send_command(start_char(), pick_angle(), b);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  // The task waits for a clock edge first so that the beat accepted at the last edge has
  // surely been noted before the pending queue is looked at.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [ANGLE_W-1:0] fc, n, e, s, w, mx);
    write_reg(REG_FULL_CIRCLE, fc);
    write_reg(REG_NORTH, n);
    write_reg(REG_EAST, e);
    write_reg(REG_SOUTH, s);
    write_reg(REG_WEST, w);
    write_reg(REG_MAX, mx);
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, 10'($urandom));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    int unsigned        phase, phase_start;
    logic [ANGLE_W-1:0] n, e, s, w;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, on the reset register values.
    send_idle_pct = 25;
    stall_pct     = 25;
    send_command(CHAR_UPPER_M, 10'd0, CHAR_CR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_UPPER_M);
    send_byte(CHAR_ZERO + 8'd1);
    send_byte(CHAR_ZERO + DECIMAL_BASE);
    send_byte(CHAR_LOWER_M);
    send_byte(CHAR_ZERO - 8'd1);
    // A start character in the middle of a command does not restart it.
    send_byte(CHAR_UPPER_M);
    send_byte(CHAR_ZERO + 8'd1);
    send_byte(CHAR_UPPER_M);
    // Nor is one taken as a start where the CR belongs.
    send_command(CHAR_UPPER_M, 10'd123, CHAR_UPPER_M);
    send_byte(CHAR_ZERO + 8'd4);
    // Out of range; the LED stays low from here on.
    send_command(CHAR_LOWER_M, 10'd999, CHAR_CR);
    wait_for_idle();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_settings(10'd360, 10'd45, 10'd135, 10'd225, 10'd315, 10'd450);
        1: apply_settings('0, '0, '0, '0, '0, '0);
        2: apply_settings('1, '1, '1, '1, '1, '1);
        3: apply_settings(10'd180, 10'd30, 10'd90, 10'd150, 10'd170, 10'd999);
        4: begin
          n = 10'($urandom_range(0, 250));
          e = n + 10'($urandom_range(0, 250));
          s = e + 10'($urandom_range(0, 250));
          w = s + 10'($urandom_range(0, 249));
          apply_settings(10'($urandom_range(0, 999)), n, e, s, w,
                         10'($urandom_range(500, 999)));
        end
        default: apply_settings(10'($urandom), 10'($urandom), 10'($urandom),
                                10'($urandom), 10'($urandom), 10'($urandom));
      endcase
      if (phase == PHASES - 1 || phase == 2) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else begin
        send_idle_pct = 10 * $urandom_range(1, 5);
        stall_pct     = 10 * $urandom_range(1, 5);
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) send_random_sequence();
      wait_for_idle();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d command bytes under %0d register settings; %0d result beats checked.",
             bytes_sent, settings_loaded + 1, sb.beats_checked);
    $display("Results: %0d ok, %0d bad command, %0d bad digits, %0d out of range.",
             sb.ok_seen, sb.bad_cmd_seen, sb.bad_digit_seen, sb.range_seen);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
